>>> sv/traffic_surge_alarm_assert.svh
// ----------------------------------------------------------------------------
// Traffic surge alarm assertion macros
// Concurrent checks on the clk domain; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_SURGE_ALARM_ASSERT_SVH
`define TRAFFIC_SURGE_ALARM_ASSERT_SVH

`ifndef SYNTHESIS
// Check that holds outside reset
`define TSA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds while reset is applied
`define TSA_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSA_ASSERT(name, prop, msg)
`define TSA_ASSERT_RST(name, prop, msg)
`endif

`endif

>>> sv/tsa_pkg.sv
// ----------------------------------------------------------------------------
// Traffic surge alarm package
// Shared widths, reset values, codes and structs.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int DEF_RATE_BITS = 32;
    localparam int FLOW_W        = 32;
    localparam int OUT_PK_W      = 32;
    localparam int TOTAL_W       = 48;
    localparam int CNT_W         = 32;
    localparam int PROD_W        = 128;
    localparam int OPB_W         = 32;
    localparam int STREAK_W      = 8;
    localparam int MOM_LIM_W     = 14;
    localparam int CHG_LIM_W     = 16;
    localparam int STR_LIM_W     = 7;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 40;
    localparam int QUEUE_DEPTH   = 4;
    localparam int MUL_STEPS     = 32;
    localparam int DIV_STEPS     = 48;
    localparam int STEP_W        = 6;
    localparam int PCT_SCALE     = 100;

    localparam logic [MOM_LIM_W-1:0] MOM_LIM_RST    = MOM_LIM_W'(40);
    localparam logic [CHG_LIM_W-1:0] CHG_LIM_RST    = CHG_LIM_W'(800);
    localparam logic [STR_LIM_W-1:0] STR_LIM_RST    = STR_LIM_W'(70);
    localparam logic [STREAK_W-1:0]  STREAK_NEED_RST = STREAK_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOMENTUM = 2'd0,
        CFG_CHANGE   = 2'd1,
        CFG_STRENGTH = 2'd2,
        CFG_STREAK   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ARITH_MUL = 1'b0,
        ARITH_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic [MOM_LIM_W-1:0] momentum_limit_pct;
        logic [CHG_LIM_W-1:0] change_ratio_limit;
        logic [STR_LIM_W-1:0] strength_limit_pct;
        logic [STREAK_W-1:0]  streak_needed;
    } cfg_t;

    // slot_packets sits in the low bits
    typedef struct packed {
        logic                alarm;
        logic                strength_hit;
        logic                strength_checked;
        logic                change_hit;
        logic                momentum_hit;
        logic [OUT_PK_W-1:0] slot_packets;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TALLY,
        ST_MOM_L,
        ST_MOM_R,
        ST_ROC_CHK,
        ST_ROC_A,
        ST_ROC_B,
        ST_STREAK,
        ST_STR_CHK,
        ST_DIV,
        ST_G1,
        ST_G2,
        ST_L1,
        ST_ZERO,
        ST_L2,
        ST_LEFT,
        ST_RIGHT,
        ST_ALARM,
        ST_DONE
    } eval_state_t;

endpackage

>>> sv/tsa_front.sv
// ----------------------------------------------------------------------------
// Traffic surge alarm front end
// Sums flow packet counts into the current slot and queues each closed slot.
// ----------------------------------------------------------------------------
module tsa_front #(
    parameter int RATE_BITS = tsa_pkg::DEF_RATE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tsa_pkg::FLOW_W-1:0]  s_tdata,
    input  logic                        s_tlast,
    input  logic                        q_full,
    output logic                        q_push,
    output logic [RATE_BITS-1:0]        q_data
);
    import tsa_pkg::*;

    localparam int SUM_W = ((RATE_BITS > FLOW_W) ? RATE_BITS : FLOW_W) + 1;
    localparam logic [SUM_W-1:0] RATE_MAX = (SUM_W'(1) << RATE_BITS) - SUM_W'(1);

    logic [RATE_BITS-1:0] slot_total_reg, slot_total_next;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     sum_sat;
    logic                 accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign sum      = SUM_W'(slot_total_reg) + SUM_W'(s_tdata);
    assign sum_sat  = (sum > RATE_MAX) ? RATE_MAX : sum;
    assign q_push   = accept && s_tlast;
    assign q_data   = sum_sat[RATE_BITS-1:0];

    always_comb
    begin
        slot_total_next = slot_total_reg;
        if (accept)
        begin
            slot_total_next = s_tlast ? '0 : sum_sat[RATE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_total_reg <= '0;
        end
        else
        begin
            slot_total_reg <= slot_total_next;
        end
    end

endmodule

>>> sv/tsa_queue.sv
// ----------------------------------------------------------------------------
// Traffic surge alarm slot queue
// Short FIFO of closed slot totals between front end and evaluator.
// ----------------------------------------------------------------------------
`include "traffic_surge_alarm_assert.svh"

module tsa_queue #(
    parameter int WIDTH = tsa_pkg::DEF_RATE_BITS,
    parameter int DEPTH = tsa_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);
    import tsa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_QW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TSA_ASSERT(a_queue_no_overflow, push |-> !full, "slot pushed into full queue")

endmodule

>>> sv/tsa_arith.sv
// ----------------------------------------------------------------------------
// Traffic surge alarm arithmetic unit
// Shared shift-add multiplier (one bit per cycle) and restoring divider.
// ----------------------------------------------------------------------------
`include "traffic_surge_alarm_assert.svh"

module tsa_arith (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsa_pkg::arith_req_t         req,
    input  logic [tsa_pkg::PROD_W-1:0]  a,
    input  logic [tsa_pkg::OPB_W-1:0]   b,
    output logic [tsa_pkg::PROD_W-1:0]  result,
    output logic                        done
);
    import tsa_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    arith_op_t         op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] a_reg, a_next;
    logic [OPB_W-1:0]  b_reg, b_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [OPB_W:0]    rem_reg, rem_next;
    logic [OPB_W:0]    rem_sh;
    logic              rem_ge;
    logic              last_step;

    assign result = acc_reg;
    assign done   = done_reg;
    assign rem_sh = {rem_reg[OPB_W-1:0], a_reg[TOTAL_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, b_reg});
    assign last_step = (op_reg == ARITH_MUL) ? (step_reg == STEP_W'(MUL_STEPS - 1))
                                             : (step_reg == STEP_W'(DIV_STEPS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        step_next = step_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            step_next = '0;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // advance one bit of the current operation
            unique case (op_reg)
                ARITH_MUL:
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                ARITH_DIV:
                begin
                    rem_next = rem_ge ? (rem_sh - {1'b0, b_reg}) : rem_sh;
                    acc_next = {acc_reg[PROD_W-2:0], rem_ge};
                    a_next   = a_reg << 1;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            step_next = step_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        step_reg <= step_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    `TSA_ASSERT(a_arith_start_idle, req.start |-> !busy_reg, "arith start while busy")
    `TSA_ASSERT(a_arith_done_busy, done_reg |-> $past(busy_reg), "arith done without work")

endmodule

>>> sv/tsa_eval.sv
// ----------------------------------------------------------------------------
// Traffic surge alarm slot evaluator
// Runs momentum, rate-of-change and strength index tests on each closed slot.
// ----------------------------------------------------------------------------
`include "traffic_surge_alarm_assert.svh"

module tsa_eval #(
    parameter int RATE_BITS = tsa_pkg::DEF_RATE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsa_pkg::cfg_t         cfg,
    input  logic [RATE_BITS-1:0]  q_head,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tsa_pkg::result_t      out_data
);
    import tsa_pkg::*;

    localparam int EXT_W = (RATE_BITS > OUT_PK_W) ? RATE_BITS : OUT_PK_W + 1;

    eval_state_t state_reg, state_next;

    logic [RATE_BITS-1:0] cur_reg, cur_next;
    logic [RATE_BITS-1:0] rate_last_reg, rate_last_next;
    logic [RATE_BITS-1:0] rate_before_reg, rate_before_next;
    logic [CNT_W-1:0]     slots_seen_reg, slots_seen_next;
    logic [TOTAL_W-1:0]   rise_total_reg, rise_total_next;
    logic [CNT_W-1:0]     rise_count_reg, rise_count_next;
    logic [TOTAL_W-1:0]   fall_total_reg, fall_total_next;
    logic [CNT_W-1:0]     fall_count_reg, fall_count_next;
    logic [STREAK_W-1:0]  streak_count_reg, streak_count_next;
    logic                 streak_flag_reg, streak_flag_next;
    logic                 alarm_reg, alarm_next;
    logic                 mom_reg, mom_next;
    logic                 roc_reg, roc_next;
    logic                 chk_reg, chk_next;
    logic                 shit_reg, shit_next;
    logic [TOTAL_W-1:0]   q_reg, q_next;
    logic [PROD_W-1:0]    t0_reg, t0_next;
    logic [PROD_W-1:0]    g_reg, g_next;
    logic [PROD_W-1:0]    l_reg, l_next;
    logic                 issued_reg, issued_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    arith_req_t           req;
    logic [PROD_W-1:0]    op_a;
    logic [OPB_W-1:0]     op_b;
    logic [PROD_W-1:0]    ar_result;
    logic                 ar_done;

    logic [RATE_BITS-1:0] diff_up;
    logic [RATE_BITS-1:0] diff_dn;
    logic                 cur_gt;
    logic                 cur_ge;
    logic [RATE_BITS-1:0] rise_val;
    logic [RATE_BITS-1:0] fall_val;
    logic [TOTAL_W:0]     rise_sum;
    logic [TOTAL_W:0]     fall_sum;
    logic                 k_ge2;
    logic                 prev_ge_res;
    logic                 cur_ge_res;
    logic [STREAK_W-1:0]  streak_inc;
    logic                 streak_flag_new;
    logic [STREAK_W-1:0]  streak_count_new;
    logic                 streak_chk;
    logic                 no_history;
    logic                 gl_zero;
    logic                 is_op_state;
    logic                 out_free;
    logic [EXT_W-1:0]     cur_wide;

    tsa_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .a      (op_a),
        .b      (op_b),
        .result (ar_result),
        .done   (ar_done)
    );

    assign diff_up     = cur_reg - rate_last_reg;
    assign diff_dn     = rate_last_reg - cur_reg;
    assign cur_gt      = cur_reg > rate_last_reg;
    assign cur_ge      = cur_reg >= rate_last_reg;
    assign rise_val    = cur_gt ? diff_up : '0;
    assign fall_val    = cur_gt ? '0 : diff_dn;
    assign rise_sum    = (TOTAL_W + 1)'(rise_total_reg) + (TOTAL_W + 1)'(diff_up);
    assign fall_sum    = (TOTAL_W + 1)'(fall_total_reg) + (TOTAL_W + 1)'(diff_dn);
    assign k_ge2       = (slots_seen_reg >= CNT_W'(2));
    assign prev_ge_res = (PROD_W'(rate_last_reg) >= ar_result);
    assign cur_ge_res  = (PROD_W'(cur_reg) >= ar_result);
    assign streak_inc  = (streak_count_reg == '1) ? streak_count_reg
                                                  : streak_count_reg + STREAK_W'(1);
    assign streak_flag_new  = roc_reg;
    assign streak_count_new = roc_reg ? streak_inc : '0;
    assign streak_chk  = streak_flag_new && (streak_count_new == cfg.streak_needed);
    assign no_history  = (rise_count_reg == '0) || (fall_count_reg == '0);
    assign gl_zero     = (g_reg == '0) && (l_reg == '0);
    assign out_free    = !out_valid_reg || out_ready;
    assign cur_wide    = EXT_W'(cur_reg);

    assign is_op_state = (state_reg == ST_MOM_L) || (state_reg == ST_MOM_R) ||
                         (state_reg == ST_ROC_A) || (state_reg == ST_ROC_B) ||
                         (state_reg == ST_DIV)   || (state_reg == ST_G1)    ||
                         (state_reg == ST_G2)    || (state_reg == ST_L1)    ||
                         (state_reg == ST_L2)    || (state_reg == ST_LEFT)  ||
                         (state_reg == ST_RIGHT);

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (!q_empty) state_next = ST_TALLY;
            ST_TALLY:
            begin
                if (slots_seen_reg == '0)
                    state_next = ST_DONE;
                else if (rate_last_reg == '0)
                    state_next = ST_ROC_CHK;
                else
                    state_next = ST_MOM_L;
            end
            ST_MOM_L:   if (ar_done) state_next = ST_MOM_R;
            ST_MOM_R:   if (ar_done) state_next = ST_ROC_CHK;
            ST_ROC_CHK:
            begin
                if (!mom_reg || !k_ge2)
                    state_next = ST_DONE;
                else if ((rate_last_reg == '0) || (rate_before_reg == '0))
                    state_next = ST_STREAK;
                else
                    state_next = ST_ROC_A;
            end
            ST_ROC_A:   if (ar_done) state_next = prev_ge_res ? ST_ROC_B : ST_STREAK;
            ST_ROC_B:   if (ar_done) state_next = ST_STREAK;
            ST_STREAK:  state_next = streak_chk ? ST_STR_CHK : ST_DONE;
            ST_STR_CHK: state_next = no_history ? ST_ALARM : ST_DIV;
            ST_DIV:     if (ar_done) state_next = ST_G1;
            ST_G1:      if (ar_done) state_next = ST_G2;
            ST_G2:      if (ar_done) state_next = ST_L1;
            ST_L1:      if (ar_done) state_next = ST_ZERO;
            ST_ZERO:    state_next = gl_zero ? ST_ALARM : ST_L2;
            ST_L2:      if (ar_done) state_next = ST_LEFT;
            ST_LEFT:    if (ar_done) state_next = ST_RIGHT;
            ST_RIGHT:   if (ar_done) state_next = ST_ALARM;
            ST_ALARM:   state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs: queue pop and arithmetic operands
    always_comb
    begin
        q_pop     = (state_reg == ST_IDLE) && !q_empty;
        req.start = is_op_state && !issued_reg;
        req.op    = (state_reg == ST_DIV) ? ARITH_DIV : ARITH_MUL;
        op_a      = '0;
        op_b      = '0;
        unique case (state_reg)
            ST_MOM_L:
            begin
                op_a = PROD_W'(cur_reg);
                op_b = OPB_W'(PCT_SCALE);
            end
            ST_MOM_R:
            begin
                op_a = PROD_W'(rate_last_reg);
                op_b = OPB_W'(cfg.momentum_limit_pct) + OPB_W'(PCT_SCALE);
            end
            ST_ROC_A:
            begin
                op_a = PROD_W'(rate_before_reg);
                op_b = OPB_W'(cfg.change_ratio_limit);
            end
            ST_ROC_B:
            begin
                op_a = PROD_W'(rate_last_reg);
                op_b = OPB_W'(cfg.change_ratio_limit);
            end
            ST_DIV:
            begin
                op_a = PROD_W'(fall_total_reg);
                op_b = fall_count_reg;
            end
            ST_G1:
            begin
                op_a = PROD_W'(rise_total_reg);
                op_b = slots_seen_reg;
            end
            ST_G2:
            begin
                op_a = PROD_W'(rise_val);
                op_b = rise_count_reg;
            end
            ST_L1:
            begin
                op_a = PROD_W'(q_reg);
                op_b = slots_seen_reg;
            end
            ST_L2:
            begin
                op_a = l_reg;
                op_b = rise_count_reg;
            end
            ST_LEFT:
            begin
                op_a = g_reg;
                op_b = OPB_W'(PCT_SCALE);
            end
            ST_RIGHT:
            begin
                op_a = t0_reg;
                op_b = OPB_W'(cfg.strength_limit_pct);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cur_next          = cur_reg;
        rate_last_next    = rate_last_reg;
        rate_before_next  = rate_before_reg;
        slots_seen_next   = slots_seen_reg;
        rise_total_next   = rise_total_reg;
        rise_count_next   = rise_count_reg;
        fall_total_next   = fall_total_reg;
        fall_count_next   = fall_count_reg;
        streak_count_next = streak_count_reg;
        streak_flag_next  = streak_flag_reg;
        alarm_next        = alarm_reg;
        mom_next          = mom_reg;
        roc_next          = roc_reg;
        chk_next          = chk_reg;
        shit_next         = shit_reg;
        q_next            = q_reg;
        t0_next           = t0_reg;
        g_next            = g_reg;
        l_next            = l_reg;
        issued_next       = is_op_state && !ar_done && (issued_reg || req.start);
        out_valid_next    = out_valid_reg && !out_ready;
        out_next          = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cur_next  = q_head;
                mom_next  = 1'b0;
                roc_next  = 1'b0;
                chk_next  = 1'b0;
                shit_next = 1'b0;
            end
            ST_TALLY:
            begin
                // gains and losses start with the third slot; a tie is a gain
                if (k_ge2)
                begin
                    if (cur_ge)
                    begin
                        rise_total_next = rise_sum[TOTAL_W] ? '1 : rise_sum[TOTAL_W-1:0];
                        if (rise_count_reg != '1)
                            rise_count_next = rise_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        fall_total_next = fall_sum[TOTAL_W] ? '1 : fall_sum[TOTAL_W-1:0];
                        if (fall_count_reg != '1)
                            fall_count_next = fall_count_reg + CNT_W'(1);
                    end
                end
                if ((slots_seen_reg != '0) && (rate_last_reg == '0))
                    mom_next = (cfg.momentum_limit_pct == '0);
            end
            ST_MOM_L:   if (ar_done) t0_next = ar_result;
            ST_MOM_R:   if (ar_done) mom_next = (t0_reg >= ar_result);
            ST_ROC_CHK: roc_next = 1'b0;
            ST_ROC_A:   if (ar_done) roc_next = 1'b0;
            ST_ROC_B:   if (ar_done) roc_next = cur_ge_res;
            ST_STREAK:
            begin
                streak_flag_next  = streak_flag_new;
                streak_count_next = streak_count_new;
                chk_next          = streak_chk;
            end
            ST_STR_CHK: if (no_history) shit_next = (cfg.strength_limit_pct == '0);
            ST_DIV:     if (ar_done) q_next = ar_result[TOTAL_W-1:0];
            ST_G1:      if (ar_done) t0_next = ar_result;
            ST_G2:      if (ar_done) g_next = t0_reg + ar_result;
            ST_L1:      if (ar_done) l_next = ar_result + PROD_W'(fall_val);
            ST_ZERO:    shit_next = 1'b0;
            ST_L2:      if (ar_done) t0_next = g_reg + ar_result;
            ST_LEFT:    if (ar_done) l_next = ar_result;
            ST_RIGHT:   if (ar_done) shit_next = (l_reg >= ar_result);
            ST_ALARM:
            begin
                if (shit_reg)
                begin
                    alarm_next        = 1'b1;
                    streak_count_next = '0;
                    streak_flag_next  = 1'b0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.slot_packets = (cur_wide > EXT_W'({OUT_PK_W{1'b1}}))
                                          ? '1 : cur_wide[OUT_PK_W-1:0];
                    out_next.momentum_hit     = mom_reg;
                    out_next.change_hit       = roc_reg;
                    out_next.strength_checked = chk_reg;
                    out_next.strength_hit     = shit_reg;
                    out_next.alarm            = alarm_reg;
                    rate_before_next = rate_last_reg;
                    rate_last_next   = cur_reg;
                    if (slots_seen_reg != '1)
                        slots_seen_next = slots_seen_reg + CNT_W'(1);
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        mom_reg <= mom_next;
        roc_reg <= roc_next;
        chk_reg <= chk_next;
        shit_reg <= shit_next;
        q_reg   <= q_next;
        t0_reg  <= t0_next;
        g_reg   <= g_next;
        l_reg   <= l_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rate_last_reg    <= '0;
            rate_before_reg  <= '0;
            slots_seen_reg   <= '0;
            rise_total_reg   <= '0;
            rise_count_reg   <= '0;
            fall_total_reg   <= '0;
            fall_count_reg   <= '0;
            streak_count_reg <= '0;
            streak_flag_reg  <= 1'b0;
            alarm_reg        <= 1'b0;
            issued_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rate_last_reg    <= rate_last_next;
            rate_before_reg  <= rate_before_next;
            slots_seen_reg   <= slots_seen_next;
            rise_total_reg   <= rise_total_next;
            rise_count_reg   <= rise_count_next;
            fall_total_reg   <= fall_total_next;
            fall_count_reg   <= fall_count_next;
            streak_count_reg <= streak_count_next;
            streak_flag_reg  <= streak_flag_next;
            alarm_reg        <= alarm_next;
            issued_reg       <= issued_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    `TSA_ASSERT(a_alarm_sticky, alarm_reg |=> alarm_reg, "latched alarm dropped")
    `TSA_ASSERT(a_change_needs_mom, out_valid_reg |-> (!out_reg.change_hit || out_reg.momentum_hit), "change hit without momentum")
    `TSA_ASSERT_RST(a_reset_no_result, !rst_n |=> !out_valid_reg, "result valid in reset")

endmodule

>>> sv/traffic_surge_alarm.sv
// Throughput: one flow record per cycle while the queue is not full; slot evaluation
//   runs behind, set by the shared serial multiplier and divider.
// Up to 4 closed slots wait in the queue; input stalls only when it is full.
// Reset (rst_n low, asynchronous) clears all slot history, the alarm and the
//   queue, and loads the limit registers with their default values.
// ----------------------------------------------------------------------------
// Traffic surge alarm
// Flags traffic surges from momentum, rate of change and strength index of
// per-slot packet totals.
// ----------------------------------------------------------------------------
module traffic_surge_alarm #(
    parameter int RATE_BITS = tsa_pkg::DEF_RATE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // flow record stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsa_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] flow_packets
    input  logic                            s_tlast,   // slot_end
    // slot result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] slot_packets, [32] momentum_hit, [33] change_hit,
    // [34] strength_checked, [35] strength_hit, [36] alarm, [39:37] zero
    output logic [tsa_pkg::OUT_DATA_W-1:0]  m_tdata,
    // limit register writes
    input  logic                            cfg_we,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tsa_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic                 q_push;
    logic [RATE_BITS-1:0] q_push_data;
    logic                 q_pop;
    logic [RATE_BITS-1:0] q_head;
    logic                 q_empty;
    logic                 q_full;
    result_t              result;

    // Limit registers: take the write on any enabled edge, keep the low bits.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MOMENTUM: cfg_next.momentum_limit_pct = cfg_data[MOM_LIM_W-1:0];
                CFG_CHANGE:   cfg_next.change_ratio_limit = cfg_data[CHG_LIM_W-1:0];
                CFG_STRENGTH: cfg_next.strength_limit_pct = cfg_data[STR_LIM_W-1:0];
                CFG_STREAK:   cfg_next.streak_needed      = cfg_data[STREAK_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.momentum_limit_pct <= MOM_LIM_RST;
            cfg_reg.change_ratio_limit <= CHG_LIM_RST;
            cfg_reg.strength_limit_pct <= STR_LIM_RST;
            cfg_reg.streak_needed      <= STREAK_NEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: sum flow counts, push the saturated total on the slot's last transfer.
    tsa_front #(
        .RATE_BITS (RATE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    // Decouple accumulation from the slow evaluation.
    tsa_queue #(
        .WIDTH (RATE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back end: evaluate one slot at a time, hold the result in an output register.
    tsa_eval #(
        .RATE_BITS (RATE_BITS)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = OUT_DATA_W'(result);

endmodule
